FILE: rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants, types and helper functions of the key state tracker.
// ----------------------------------------------------------------------------
package kst_pkg;

  // Store geometry
  localparam int NUM_KEYS = 512;
  localparam int ADDR_W   = $clog2(NUM_KEYS);
  localparam int CNT_W    = $clog2(NUM_KEYS + 1);

  // Beat field widths
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 10;
  localparam int STATE_W = 4;
  localparam int FKEY_W  = 9;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_EVENT = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_e;

  // Key states
  localparam logic [STATE_W-1:0] K_OFF     = 4'd0;
  localparam logic [STATE_W-1:0] K_ON      = 4'd1;
  localparam logic [STATE_W-1:0] K_DOWN    = 4'd2;
  localparam logic [STATE_W-1:0] K_STRUCK  = 4'd3;
  localparam logic [STATE_W-1:0] K_PRESSED = 4'd4;
  localparam logic [STATE_W-1:0] K_HELD1   = 4'd5;
  localparam logic [STATE_W-1:0] K_HELD2   = 4'd6;
  localparam logic [STATE_W-1:0] K_HELD3   = 4'd7;
  localparam logic [STATE_W-1:0] K_REPEAT  = 4'd8;

  // Special key codes
  localparam int CODE_ESCAPE = 27;
  localparam int CODE_Q      = 113;
  localparam int CODE_SHIFT  = 303;  // first of the shift/ctrl/alt pairs
  localparam int NUM_MODS    = 6;    // 303..308 feed the flags

  // Register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MODE = 1'b0;  // word index of joystick_mode

  // Result beat contents (flags are added at output)
  typedef struct packed {
    logic [STATE_W-1:0] key_state;
    logic               found;
    logic [FKEY_W-1:0]  found_key;
    logic               quit_key;
  } res_t;

  // Keys that only go on or off
  function automatic logic is_modifier(logic [ADDR_W-1:0] code);
    logic m;
    m = (code == ADDR_W'(300)) || (code == ADDR_W'(301)) ||
        (code == ADDR_W'(303)) || (code == ADDR_W'(304)) ||
        (code == ADDR_W'(305)) || (code == ADDR_W'(306)) ||
        (code == ADDR_W'(307)) || (code == ADDR_W'(308)) ||
        (code == ADDR_W'(309)) || (code == ADDR_W'(310)) ||
        (code == ADDR_W'(313));
    return m;
  endfunction

  // Tick transition, joystick or keyboard flavour
  function automatic logic [STATE_W-1:0] tick_next(logic joy, logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] n;
    unique case (s)
      K_OFF:     n = K_OFF;
      K_ON:      n = K_ON;
      K_DOWN:    n = K_DOWN;
      K_STRUCK:  n = K_OFF;
      K_PRESSED: n = joy ? K_DOWN : K_HELD1;
      K_HELD1:   n = joy ? K_DOWN : K_HELD2;
      K_HELD2:   n = K_DOWN;
      K_HELD3:   n = K_DOWN;
      K_REPEAT:  n = K_DOWN;
      default:   n = K_OFF;
    endcase
    return n;
  endfunction

  // Key event transition for ordinary keys
  function automatic logic [STATE_W-1:0] event_next(logic down, logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] n;
    if (down) begin
      n = (s == K_OFF) ? K_PRESSED : K_REPEAT;
    end else begin
      n = (s == K_PRESSED) ? K_STRUCK : K_OFF;
    end
    return n;
  endfunction

endpackage

FILE: rtl/kst_in_if.sv
// ----------------------------------------------------------------------------
// kst_in_if
// Command channel of the key state tracker: valid/ready plus command beat.
// ----------------------------------------------------------------------------
interface kst_in_if;
  logic                         valid;
  logic                         ready;
  logic [kst_pkg::CMD_W-1:0]    cmd;
  logic [kst_pkg::CODE_W-1:0]   key_code;
  logic                         key_down;

  modport source (output valid, output cmd, output key_code, output key_down,
                  input ready);
  modport sink   (input valid, input cmd, input key_code, input key_down,
                  output ready);
endinterface

FILE: rtl/kst_out_if.sv
// ----------------------------------------------------------------------------
// kst_out_if
// Result channel of the key state tracker: valid/ready plus result beat.
// ----------------------------------------------------------------------------
interface kst_out_if;
  logic                          valid;
  logic                          ready;
  logic [kst_pkg::STATE_W-1:0]   key_state;
  logic                          found;
  logic [kst_pkg::FKEY_W-1:0]    found_key;
  logic                          quit_key;
  logic                          shift_down;
  logic                          ctrl_down;
  logic                          alt_down;

  modport source (output valid, output key_state, output found, output found_key,
                  output quit_key, output shift_down, output ctrl_down,
                  output alt_down, input ready);
  modport sink   (input valid, input key_state, input found, input found_key,
                  input quit_key, input shift_down, input ctrl_down,
                  input alt_down, output ready);
endinterface

FILE: rtl/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/key_state_tracker.sv
// ----------------------------------------------------------------------------
// key_state_tracker
// Per-key 4-bit state store with key events, ticks, reads and a lowest
// active key search, built around one synchronous RAM.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake             Beat contents
//  in_i      in    valid/ready           cmd, key_code, key_down
//  out_o     out   valid/ready           key_state, found, found_key, quit_key,
//                                        shift_down, ctrl_down, alt_down
//  APB       in    psel/penable, pready  joystick_mode at word 0
//
//  Key event and read: RAM read, update, response.
//  Tick: one entry a cycle through the RAM read/write ports.
//  Find: scans upward from key 0 and stops at the first hit or after the last key.
//  After reset a clearing pass writes every entry, with in_i not ready. A
//  stalled result holds in the output register; the next command is taken
//  once the pending result has moved there.
// ----------------------------------------------------------------------------
module key_state_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kst_in_if.sink                      in_i,
  kst_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kst_pkg::PADDR_W-1:0] paddr,
  input  logic [kst_pkg::PDATA_W-1:0] pwdata,
  output logic [kst_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW = kst_pkg::ADDR_W;
  localparam int CW = kst_pkg::CNT_W;
  localparam int SW = kst_pkg::STATE_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVENT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_FIND  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] prev_addr;

  logic          mode_q;
  logic [kst_pkg::NUM_MODS-1:0] mod_q;

  logic [AW-1:0] code_q;
  logic          code_ok_q;
  logic          down_q;
  logic          code_ok_in;
  logic          in_fire;

  kst_pkg::res_t res_q, res_d;
  kst_pkg::res_t out_q;
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [2:0]    flags_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic          hit;
  logic          cfg_wr;

  // State store
  kst_ram #(
    .WIDTH (SW),
    .DEPTH (kst_pkg::NUM_KEYS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == kst_pkg::REG_MODE);
  assign prdata = (paddr[2] == kst_pkg::REG_MODE) ? kst_pkg::PDATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  // Input beat capture
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign code_ok_in = (11'(in_i.key_code) < 11'(kst_pkg::NUM_KEYS));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q    <= in_i.key_code[AW-1:0];
      code_ok_q <= code_ok_in;
      down_q    <= in_i.key_down;
    end
  end

  // Sweep helpers: entry cnt_q-1 is the one whose data is back
  assign cnt_m1    = cnt_q - CW'(1);
  assign prev_addr = cnt_m1[AW-1:0];
  assign hit = (ram_rdata == kst_pkg::K_STRUCK) || (ram_rdata == kst_pkg::K_PRESSED) ||
               (ram_rdata == kst_pkg::K_REPEAT);
  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = kst_pkg::K_OFF;
        if (cnt_q == CW'(kst_pkg::NUM_KEYS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        res_d = '0;
        cnt_d = '0;
        if (in_fire) begin
          ram_raddr = in_i.key_code[AW-1:0];
          unique case (kst_pkg::cmd_e'(in_i.cmd))
            kst_pkg::CMD_EVENT: begin
              ram_re  = code_ok_in;
              state_d = S_EVENT;
            end
            kst_pkg::CMD_TICK: state_d = S_TICK;
            kst_pkg::CMD_READ: begin
              ram_re  = code_ok_in;
              state_d = S_READ;
            end
            kst_pkg::CMD_FIND: state_d = S_FIND;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_EVENT: begin
        if (code_ok_q) begin
          ram_we    = 1'b1;
          ram_waddr = code_q;
          if (kst_pkg::is_modifier(code_q)) begin
            ram_wdata = down_q ? kst_pkg::K_ON : kst_pkg::K_OFF;
          end else begin
            ram_wdata = kst_pkg::event_next(down_q, ram_rdata);
          end
          res_d.key_state = ram_wdata;
        end
        state_d = S_RESP;
      end
      S_READ: begin
        res_d.key_state = code_ok_q ? ram_rdata : kst_pkg::K_OFF;
        state_d         = S_RESP;
      end
      S_TICK: begin
        // read entry cnt_q, write back entry cnt_q-1
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = prev_addr;
          ram_wdata = kst_pkg::tick_next(mode_q, ram_rdata);
        end
        if (cnt_q == CW'(kst_pkg::NUM_KEYS)) begin
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
      end
      S_FIND: begin
        if ((cnt_q != '0) && hit) begin
          res_d.key_state = ram_rdata;
          res_d.found     = 1'b1;
          res_d.found_key = prev_addr[kst_pkg::FKEY_W-1:0];
          res_d.quit_key  = (prev_addr == AW'(kst_pkg::CODE_Q)) ||
                            (prev_addr == AW'(kst_pkg::CODE_ESCAPE));
          state_d         = S_RESP;
        end else if (cnt_q == CW'(kst_pkg::NUM_KEYS)) begin
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Shadow of the shift/ctrl/alt entries, tracking every store write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
    end else begin
      for (int i = 0; i < kst_pkg::NUM_MODS; i++) begin
        if (ram_we && (ram_waddr == AW'(kst_pkg::CODE_SHIFT + i))) begin
          mod_q[i] <= (ram_wdata != kst_pkg::K_OFF);
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q   <= res_q;
      flags_q <= {mod_q[5] | mod_q[4], mod_q[3] | mod_q[2], mod_q[1] | mod_q[0]};
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.key_state  = out_q.key_state;
  assign out_o.found      = out_q.found;
  assign out_o.found_key  = out_q.found_key;
  assign out_o.quit_key   = out_q.quit_key;
  assign out_o.shift_down = flags_q[0];
  assign out_o.ctrl_down  = flags_q[1];
  assign out_o.alt_down   = flags_q[2];

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key state tracker. A short table of commands
// walks the corner cases (reset contents, codes beyond the store, modifier
// flags, quit keys, struck and repeating keys), then random command beats,
// mostly on a small set of hot keys, drive the store through its tick tables
// in both modes. Every result beat is checked field by field against a typed
// row's result or a key store mirror, under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int DIR_ROWS      = 28;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 4;
  localparam int SETTLE_CYCLES = 600;   // longer than a full walk of the store

  localparam int SRC_IDLE   [NUM_PHASES] = '{0, 65, 0, 24};
  localparam int SINK_STALL [NUM_PHASES] = '{0, 0, 65, 24};
  localparam bit PHASE_MODE [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

  // Keys that only go on or off
  localparam int MOD_CODES [11] = '{300, 301, 303, 304, 305, 306, 307, 308, 309, 310, 313};

  // One result beat
  typedef struct packed {
    logic [kst_pkg::STATE_W-1:0] key_state;
    logic                        found;
    logic [kst_pkg::FKEY_W-1:0]  found_key;
    logic                        quit_key;
    logic                        shift_down;
    logic                        ctrl_down;
    logic                        alt_down;
  } key_result_t;

  // One row of the directed table; typed rows carry their result
  typedef struct packed {
    kst_pkg::cmd_e              cmd;
    logic [kst_pkg::CODE_W-1:0] code;
    logic                       down;
    logic                       typed;
    key_result_t                res;
  } cmd_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [kst_pkg::PADDR_W-1:0]  paddr;
  logic [kst_pkg::PDATA_W-1:0]  pwdata;
  logic [kst_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  kst_in_if  cmd_ch ();
  kst_out_if res_ch ();

  key_state_tracker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block's state
  logic [kst_pkg::STATE_W-1:0] key_mirror [kst_pkg::NUM_KEYS] = '{default: kst_pkg::K_OFF};
  logic                        mode_mirror = 1'b0;

  key_result_t pending_results [$];
  int          err_count      = 0;
  int          cycle_count    = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;

  // Directed table: reset contents, store bounds, flags, quit keys, key cycle
  cmd_row_t directed_cmds [DIR_ROWS] = '{
    '{kst_pkg::CMD_READ,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_OFF, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_READ,  10'd1023, 1'b0, 1'b1,
      '{kst_pkg::K_OFF, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_OFF, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd511,  1'b1, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd1023, 1'b1, 1'b1,
      '{kst_pkg::K_OFF, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd512,  1'b0, 1'b1,
      '{kst_pkg::K_OFF, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd303,  1'b1, 1'b1,
      '{kst_pkg::K_ON, 1'b0, 9'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd306,  1'b1, 1'b1,
      '{kst_pkg::K_ON, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{kst_pkg::CMD_EVENT, 10'd307,  1'b1, 1'b1,
      '{kst_pkg::K_ON, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b1, 9'd511, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_EVENT, 10'd113,  1'b1, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b1, 9'd113, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_EVENT, 10'd27,   1'b1, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b1, 9'd27, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_EVENT, 10'd27,   1'b0, 1'b1,
      '{kst_pkg::K_STRUCK, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_STRUCK, 1'b1, 9'd27, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_EVENT, 10'd27,   1'b1, 1'b1,
      '{kst_pkg::K_REPEAT, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_REPEAT, 1'b1, 9'd27, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_EVENT, 10'd0,    1'b1, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b0, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b1,
      '{kst_pkg::K_PRESSED, 1'b1, 9'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{kst_pkg::CMD_TICK,  10'd1023, 1'b1, 1'b0, '0},
    '{kst_pkg::CMD_READ,  10'd0,    1'b0, 1'b0, '0},
    '{kst_pkg::CMD_EVENT, 10'd303,  1'b0, 1'b0, '0},
    '{kst_pkg::CMD_EVENT, 10'd300,  1'b1, 1'b0, '0},
    '{kst_pkg::CMD_EVENT, 10'd0,    1'b0, 1'b0, '0},
    '{kst_pkg::CMD_TICK,  10'd0,    1'b0, 1'b0, '0},
    '{kst_pkg::CMD_FIND,  10'd0,    1'b0, 1'b0, '0},
    '{kst_pkg::CMD_READ,  10'd27,   1'b0, 1'b0, '0}
  };

  function automatic logic modifier_key(logic [kst_pkg::CODE_W-1:0] code);
    logic hit;
    hit = 1'b0;
    foreach (MOD_CODES[m]) begin
      if (code == kst_pkg::CODE_W'(MOD_CODES[m])) hit = 1'b1;
    end
    return hit;
  endfunction

  // Tick table, joystick or keyboard
  function automatic logic [kst_pkg::STATE_W-1:0] ticked(logic joy,
                                                         logic [kst_pkg::STATE_W-1:0] s);
    logic [kst_pkg::STATE_W-1:0] n;
    case (s)
      kst_pkg::K_OFF, kst_pkg::K_STRUCK: n = kst_pkg::K_OFF;
      kst_pkg::K_ON:                     n = kst_pkg::K_ON;
      kst_pkg::K_DOWN:                   n = kst_pkg::K_DOWN;
      kst_pkg::K_PRESSED:                n = joy ? kst_pkg::K_DOWN : kst_pkg::K_HELD1;
      kst_pkg::K_HELD1:                  n = joy ? kst_pkg::K_DOWN : kst_pkg::K_HELD2;
      kst_pkg::K_HELD2, kst_pkg::K_HELD3, kst_pkg::K_REPEAT:
                                         n = kst_pkg::K_DOWN;
      default:                           n = kst_pkg::K_OFF;
    endcase
    return n;
  endfunction

  // Applies one command beat to the mirror and returns the result it gives
  function automatic key_result_t apply_command(kst_pkg::cmd_e c,
                                                logic [kst_pkg::CODE_W-1:0] code, logic dn);
    key_result_t                 r;
    logic [kst_pkg::STATE_W-1:0] s;
    r = '0;
    case (c)
      kst_pkg::CMD_EVENT: begin
        if (code < kst_pkg::NUM_KEYS) begin
          s = key_mirror[code[kst_pkg::ADDR_W-1:0]];
          if (modifier_key(code)) s = dn ? kst_pkg::K_ON : kst_pkg::K_OFF;
          else if (dn) s = (s == kst_pkg::K_OFF) ? kst_pkg::K_PRESSED : kst_pkg::K_REPEAT;
          else s = (s == kst_pkg::K_PRESSED) ? kst_pkg::K_STRUCK : kst_pkg::K_OFF;
          key_mirror[code[kst_pkg::ADDR_W-1:0]] = s;
          r.key_state = s;
        end
      end
      kst_pkg::CMD_TICK: begin
        for (int n = 0; n < kst_pkg::NUM_KEYS; n++) begin
          key_mirror[n] = ticked(mode_mirror, key_mirror[n]);
        end
      end
      kst_pkg::CMD_READ: begin
        if (code < kst_pkg::NUM_KEYS) r.key_state = key_mirror[code[kst_pkg::ADDR_W-1:0]];
      end
      default: begin
        for (int n = 0; n < kst_pkg::NUM_KEYS && !r.found; n++) begin
          s = key_mirror[n];
          if (s == kst_pkg::K_STRUCK || s == kst_pkg::K_PRESSED || s == kst_pkg::K_REPEAT) begin
            r.found     = 1'b1;
            r.found_key = kst_pkg::FKEY_W'(n);
            r.quit_key  = (n == kst_pkg::CODE_Q) || (n == kst_pkg::CODE_ESCAPE);
            r.key_state = s;
          end
        end
      end
    endcase
    r.shift_down = (key_mirror[kst_pkg::CODE_SHIFT]     != kst_pkg::K_OFF) ||
                   (key_mirror[kst_pkg::CODE_SHIFT + 1] != kst_pkg::K_OFF);
    r.ctrl_down  = (key_mirror[kst_pkg::CODE_SHIFT + 2] != kst_pkg::K_OFF) ||
                   (key_mirror[kst_pkg::CODE_SHIFT + 3] != kst_pkg::K_OFF);
    r.alt_down   = (key_mirror[kst_pkg::CODE_SHIFT + 4] != kst_pkg::K_OFF) ||
                   (key_mirror[kst_pkg::CODE_SHIFT + 5] != kst_pkg::K_OFF);
    return r;
  endfunction

  // Keys that random traffic keeps returning to, so sequences build up
  function automatic logic [kst_pkg::CODE_W-1:0] hot_key();
    logic [kst_pkg::CODE_W-1:0] k;
    case ($urandom_range(7))
      0:       k = kst_pkg::CODE_W'(MOD_CODES[$urandom_range(10)]);
      1:       k = kst_pkg::CODE_W'(kst_pkg::CODE_ESCAPE);
      2:       k = kst_pkg::CODE_W'(kst_pkg::CODE_Q);
      3:       k = kst_pkg::CODE_W'($urandom_range(3));
      4:       k = kst_pkg::CODE_W'(kst_pkg::NUM_KEYS - 1);
      5:       k = kst_pkg::CODE_W'($urandom_range(47, 40));
      default: k = kst_pkg::CODE_W'($urandom_range(kst_pkg::NUM_KEYS - 1));
    endcase
    return k;
  endfunction

  // Present one command beat, wait for it to be taken, queue its result
  task automatic send_command(input kst_pkg::cmd_e c, input logic [kst_pkg::CODE_W-1:0] code,
                              input logic dn, input logic typed,
                              input key_result_t typed_res);
    key_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= c;
    cmd_ch.key_code <= code;
    cmd_ch.key_down <= dn;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    r = apply_command(c, code, dn);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Hold the sender off until every queued result has come back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // APB write of the mode register; upper data bits are don't-care
  task automatic write_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kst_pkg::PADDR_W'(4 * int'(kst_pkg::REG_MODE));
    pwdata  <= {(kst_pkg::PDATA_W-1)'($urandom), m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mode_mirror = m;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_command();
    int                         roll;
    kst_pkg::cmd_e              c;
    logic [kst_pkg::CODE_W-1:0] code;
    logic                       dn;
    roll = $urandom_range(99);
    dn   = 1'($urandom_range(1));
    code = hot_key();
    if (roll < 40) begin
      c = kst_pkg::CMD_EVENT;
    end else if (roll < 58) begin
      c = kst_pkg::CMD_READ;
    end else if (roll < 72) begin
      // noise over the whole code range, beyond the store included
      c    = roll[0] ? kst_pkg::CMD_EVENT : kst_pkg::CMD_READ;
      code = kst_pkg::CODE_W'($urandom_range(1023));
    end else begin
      c    = (roll < 87) ? kst_pkg::CMD_TICK : kst_pkg::CMD_FIND;
      code = kst_pkg::CODE_W'($urandom_range(1023));
    end
    send_command(c, code, dn, 1'b0, '0);
  endtask

  task automatic compare_result(input key_result_t want, input key_result_t got);
    if (got.key_state !== want.key_state) begin
      $error("key_state expected %0d got %0d", want.key_state, got.key_state);
      err_count++;
    end
    if (got.found !== want.found) begin
      $error("found expected %0d got %0d", want.found, got.found);
      err_count++;
    end
    if (got.found_key !== want.found_key) begin
      $error("found_key expected %0d got %0d", want.found_key, got.found_key);
      err_count++;
    end
    if (got.quit_key !== want.quit_key) begin
      $error("quit_key expected %0d got %0d", want.quit_key, got.quit_key);
      err_count++;
    end
    if (got.shift_down !== want.shift_down) begin
      $error("shift_down expected %0d got %0d", want.shift_down, got.shift_down);
      err_count++;
    end
    if (got.ctrl_down !== want.ctrl_down) begin
      $error("ctrl_down expected %0d got %0d", want.ctrl_down, got.ctrl_down);
      err_count++;
    end
    if (got.alt_down !== want.alt_down) begin
      $error("alt_down expected %0d got %0d", want.alt_down, got.alt_down);
      err_count++;
    end
  endtask

  // Result side: check each accepted beat, then pick the next ready
  always @(posedge clk_i) begin : result_monitor
    key_result_t got;
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = '{res_ch.key_state, res_ch.found, res_ch.found_key, res_ch.quit_key,
              res_ch.shift_down, res_ch.ctrl_down, res_ch.alt_down};
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
    end
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL key_state_tracker");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.cmd      <= kst_pkg::CMD_EVENT;
    cmd_ch.key_code <= '0;
    cmd_ch.key_down <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    // Directed corner cases, keyboard mode, no idling
    foreach (directed_cmds[r]) begin
      send_command(directed_cmds[r].cmd, directed_cmds[r].code, directed_cmds[r].down,
                   directed_cmds[r].typed, directed_cmds[r].res);
    end

    // Random traffic, mode and idling pattern changed per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      drain_results();
      write_mode(PHASE_MODE[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(49) == 0) drain_results();
        random_command();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS key_state_tracker");
    end else begin
      $display("FAIL key_state_tracker");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/kst_pkg.sv
rtl/kst_in_if.sv
rtl/kst_out_if.sv
rtl/kst_ram.sv
rtl/key_state_tracker.sv
test/tb_top.sv
